// File: rtl/tpl_pkg.sv
// Shared types, codes and constants for the triangle point locator.
`timescale 1ns / 1ps
`default_nettype none

package tpl_pkg;

	localparam int COORD_W = 32;
	localparam int INDEX_W = 8;
	localparam int LIMIT_W = 40;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int ACC_W   = PROD_W + 1;

	localparam int DEF_MAX_VERTICES  = 256;
	localparam int DEF_MAX_TRIANGLES = 256;
	localparam int DEF_FRAC_BITS     = 16;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 40'd1000000;

	typedef logic [2:0] cmd_t;
	localparam cmd_t CMD_LOAD_VTX = 3'd0;
	localparam cmd_t CMD_LOAD_TRI = 3'd1;
	localparam cmd_t CMD_LOCATE   = 3'd2;
	localparam cmd_t CMD_NEAREST  = 3'd3;
	localparam cmd_t CMD_CLEAR    = 3'd4;

	typedef logic [1:0] status_t;
	localparam status_t STAT_OK   = 2'd0;
	localparam status_t STAT_FULL = 2'd1;
	localparam status_t STAT_NONE = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_L_TRI,
		S_L_CHK,
		S_L_VTX,
		S_L_MUL,
		S_L_WAIT,
		S_N_RD,
		S_N_X,
		S_N_Y,
		S_N_WAIT
	} state_t;

	// One product issued to the multiply-accumulate unit.
	typedef struct packed {
		logic               valid;
		logic               first;
		logic               sub;
		logic               last;
		logic [INDEX_W-1:0] tag;
	} mac_op_t;

	// Finished sum of products, two's complement.
	typedef struct packed {
		logic               valid;
		logic [INDEX_W-1:0] tag;
		logic [ACC_W-1:0]   acc;
	} mac_res_t;

endpackage

`default_nettype wire

// File: rtl/tpl_ram.sv
// Simple dual-port memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tpl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/tpl_mac.sv
// Shared unit: difference, exact signed multiply, accumulate.
`timescale 1ns / 1ps
`default_nettype none

module tpl_mac import tpl_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire mac_op_t                   op,
	input  wire logic signed [COORD_W-1:0] a1,
	input  wire logic signed [COORD_W-1:0] a2,
	input  wire logic signed [COORD_W-1:0] b1,
	input  wire logic signed [COORD_W-1:0] b2,
	output mac_res_t                       res,
	output logic                           busy
);

	mac_op_t                   op_s1;
	mac_op_t                   op_s2;
	logic signed [DIFF_W-1:0]  da_s1;
	logic signed [DIFF_W-1:0]  db_s1;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   acc_base;
	logic signed [ACC_W-1:0]   prod_ext;
	logic                      res_valid_q;
	logic [INDEX_W-1:0]        tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1       <= '0;
			op_s2       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			op_s1       <= op;
			op_s2       <= op_s1;
			res_valid_q <= op_s2.valid & op_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		da_s1   <= {a1[COORD_W-1], a1} - {a2[COORD_W-1], a2};
		db_s1   <= {b1[COORD_W-1], b1} - {b2[COORD_W-1], b2};
		prod_s2 <= da_s1 * db_s1;
	end

	assign prod_ext = {prod_s2[PROD_W-1], prod_s2};
	assign acc_base = op_s2.first ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (op_s2.valid) begin
			acc_q <= op_s2.sub ? (acc_base - prod_ext) : (acc_base + prod_ext);
			tag_q <= op_s2.tag;
		end
	end

	assign res  = '{valid: res_valid_q, tag: tag_q, acc: acc_q};
	assign busy = op_s1.valid | op_s2.valid | res_valid_q;

endmodule

`default_nettype wire

// File: rtl/triangle_point_locator.sv
// Top level: stores, command sequencer and result register of the point locator.
//
//   channel   handshake                 payload
//   command   start / busy              command, point_x, point_y, corner_a..c
//   result    done (one-cycle strobe)   status, found_index
//   config    distance_limit_we         distance_limit_wdata
//
// Load, clear and unknown commands never leave idle; done follows in the next cycle.
// Locate: skipped triangles take no products; each checked triangle issues six products to one
// shared 33x33 multiplier and then waits for its 3-stage drain.
// Nearest: two products per stored vertex on the same unit.
// busy is high while a query scans; the receiver takes each result as it comes.
// Reset clears both counts and sets distance_limit to 1000000; memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module triangle_point_locator import tpl_pkg::*; #(
	parameter int MAX_VERTICES  = DEF_MAX_VERTICES,
	parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES,
	parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [2:0]                command,
	input  wire logic signed [COORD_W-1:0] point_x,
	input  wire logic signed [COORD_W-1:0] point_y,
	input  wire logic [INDEX_W-1:0]        corner_a,
	input  wire logic [INDEX_W-1:0]        corner_b,
	input  wire logic [INDEX_W-1:0]        corner_c,
	input  wire logic                      distance_limit_we,
	input  wire logic [LIMIT_W-1:0]        distance_limit_wdata,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [INDEX_W-1:0]             found_index
);

	localparam int VAW   = $clog2(MAX_VERTICES);
	localparam int TAW   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
	localparam int VCW   = $clog2(MAX_VERTICES + 1);
	localparam int TCW   = $clog2(MAX_TRIANGLES + 1);
	localparam int IDX_W = (VCW > TCW) ? VCW : TCW;
	localparam int CRW   = (VCW > INDEX_W) ? VCW : INDEX_W;
	localparam int SHIFT = 2 * FRAC_BITS;
	localparam int LIM_W = LIMIT_W + SHIFT;
	localparam int CMP_W = (LIM_W > ACC_W) ? LIM_W : ACC_W;

	localparam logic [1:0] LAST_K = 2'd2;
	localparam logic [2:0] LAST_J = 3'd5;

	state_t                    state_q, state_d;
	cmd_t                      cmd_q;
	logic signed [COORD_W-1:0] px_q, py_q;
	logic [IDX_W-1:0]          idx_q, idx_nx;
	logic [2:0]                j_q;
	logic [1:0]                k_q;
	logic [INDEX_W-1:0]        c1_q, c2_q;
	logic signed [COORD_W-1:0] v0x_q, v0y_q, v1x_q, v1y_q, v2x_q, v2y_q;
	logic                      ok_q;
	logic                      found_q;
	logic [INDEX_W-1:0]        fidx_q;
	logic [CMP_W-1:0]          best_q;
	logic [VCW-1:0]            vcount_q;
	logic [TCW-1:0]            tcount_q;
	logic [LIMIT_W-1:0]        limit_q;

	logic                      accept;
	logic                      vfull, tfull, last_v, last_t;
	logic                      vram_we, tram_we;
	logic [VAW-1:0]            vram_raddr;
	logic [TAW-1:0]            tram_raddr;
	logic [2*COORD_W-1:0]      vram_rdata;
	logic [3*INDEX_W-1:0]      tram_rdata;
	logic [INDEX_W-1:0]        tri_a, tri_b, tri_c;
	logic                      tri_bad;
	logic signed [COORD_W-1:0] vtx_x, vtx_y;

	mac_op_t                   mop;
	logic signed [COORD_W-1:0] ma1, ma2, mb1, mb2;
	mac_res_t                  mres;
	logic                      mac_busy;
	logic [CMP_W-1:0]          sum_sq;
	logic                      closer, acc_pos;

	logic                      rv_d;
	status_t                   rstat_d;
	logic [INDEX_W-1:0]        ridx_d;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && (state_q == S_IDLE);
	assign idx_nx = idx_q + IDX_W'(1);
	assign last_v = idx_nx >= IDX_W'(vcount_q);
	assign last_t = idx_nx >= IDX_W'(tcount_q);
	assign vfull  = vcount_q == VCW'(MAX_VERTICES);
	assign tfull  = tcount_q == TCW'(MAX_TRIANGLES);

	assign vram_we = accept && (command == CMD_LOAD_VTX) && !vfull;
	assign tram_we = accept && (command == CMD_LOAD_TRI) && !tfull;

	tpl_ram #(
		.WIDTH(2 * COORD_W),
		.DEPTH(MAX_VERTICES),
		.AW   (VAW)
	) u_vram (
		.clk  (clk),
		.we   (vram_we),
		.waddr(VAW'(vcount_q)),
		.wdata({point_x, point_y}),
		.raddr(vram_raddr),
		.rdata(vram_rdata)
	);

	tpl_ram #(
		.WIDTH(3 * INDEX_W),
		.DEPTH(MAX_TRIANGLES),
		.AW   (TAW)
	) u_tram (
		.clk  (clk),
		.we   (tram_we),
		.waddr(TAW'(tcount_q)),
		.wdata({corner_c, corner_b, corner_a}),
		.raddr(tram_raddr),
		.rdata(tram_rdata)
	);

	tpl_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (mop),
		.a1    (ma1),
		.a2    (ma2),
		.b1    (mb1),
		.b2    (mb2),
		.res   (mres),
		.busy  (mac_busy)
	);

	assign tri_a = tram_rdata[INDEX_W-1:0];
	assign tri_b = tram_rdata[2*INDEX_W-1:INDEX_W];
	assign tri_c = tram_rdata[3*INDEX_W-1:2*INDEX_W];

	// skip triangles that name a vertex not loaded yet
	assign tri_bad = (CRW'(tri_a) >= CRW'(vcount_q)) ||
	                 (CRW'(tri_b) >= CRW'(vcount_q)) ||
	                 (CRW'(tri_c) >= CRW'(vcount_q));

	assign vtx_x = vram_rdata[2*COORD_W-1:COORD_W];
	assign vtx_y = vram_rdata[COORD_W-1:0];

	assign sum_sq  = CMP_W'(mres.acc);
	assign closer  = sum_sq < best_q;
	assign acc_pos = !mres.acc[ACC_W-1] && (mres.acc != '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (command == CMD_LOCATE && tcount_q != '0) begin
						state_d = S_L_TRI;
					end else if (command == CMD_NEAREST && vcount_q != '0) begin
						state_d = S_N_RD;
					end
				end
			end
			S_L_TRI: state_d = S_L_CHK;
			S_L_CHK: begin
				if (!tri_bad) begin
					state_d = S_L_VTX;
				end else if (last_t) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_L_TRI;
				end
			end
			S_L_VTX: begin
				if (k_q == LAST_K) begin
					state_d = S_L_MUL;
				end
			end
			S_L_MUL: begin
				if (j_q == LAST_J) begin
					state_d = S_L_WAIT;
				end
			end
			S_L_WAIT: begin
				if (!mac_busy) begin
					state_d = (ok_q || last_t) ? S_IDLE : S_L_TRI;
				end
			end
			S_N_RD: state_d = S_N_X;
			S_N_X: state_d = S_N_Y;
			S_N_Y: state_d = last_v ? S_N_WAIT : S_N_X;
			S_N_WAIT: begin
				if (!mac_busy) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		vram_raddr = '0;
		tram_raddr = '0;
		mop        = '0;
		ma1        = '0;
		ma2        = '0;
		mb1        = '0;
		mb2        = '0;
		rv_d       = 1'b0;
		rstat_d    = STAT_OK;
		ridx_d     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (command)
						CMD_LOAD_VTX: begin
							rv_d    = 1'b1;
							rstat_d = vfull ? STAT_FULL : STAT_OK;
							ridx_d  = vfull ? '0 : INDEX_W'(vcount_q);
						end
						CMD_LOAD_TRI: begin
							rv_d    = 1'b1;
							rstat_d = tfull ? STAT_FULL : STAT_OK;
							ridx_d  = tfull ? '0 : INDEX_W'(tcount_q);
						end
						CMD_LOCATE: begin
							rv_d    = (tcount_q == '0);
							rstat_d = STAT_NONE;
						end
						CMD_NEAREST: begin
							rv_d    = (vcount_q == '0);
							rstat_d = STAT_NONE;
						end
						default: rv_d = 1'b1;
					endcase
				end
			end
			S_L_TRI: tram_raddr = TAW'(idx_q);
			S_L_CHK: begin
				vram_raddr = VAW'(tri_a);
				if (tri_bad && last_t) begin
					rv_d    = 1'b1;
					rstat_d = STAT_NONE;
				end
			end
			S_L_VTX: vram_raddr = VAW'(c1_q);
			S_L_MUL: begin
				// even step: (Bx-Ax)*(Py-Ay); odd step subtracts (By-Ay)*(Px-Ax)
				mop.valid = 1'b1;
				mop.first = !j_q[0];
				mop.sub   = j_q[0];
				mop.last  = j_q[0];
				mop.tag   = INDEX_W'(idx_q);
				if (!j_q[0]) begin
					ma1 = v1x_q;
					ma2 = v0x_q;
					mb1 = py_q;
					mb2 = v0y_q;
				end else begin
					ma1 = v1y_q;
					ma2 = v0y_q;
					mb1 = px_q;
					mb2 = v0x_q;
				end
			end
			S_L_WAIT: begin
				if (!mac_busy) begin
					if (ok_q) begin
						rv_d   = 1'b1;
						ridx_d = INDEX_W'(idx_q);
					end else if (last_t) begin
						rv_d    = 1'b1;
						rstat_d = STAT_NONE;
					end
				end
			end
			S_N_RD: vram_raddr = VAW'(idx_q);
			S_N_X: begin
				vram_raddr = VAW'(idx_q);
				mop.valid  = 1'b1;
				mop.first  = 1'b1;
				mop.tag    = INDEX_W'(idx_q);
				ma1        = vtx_x;
				ma2        = px_q;
				mb1        = vtx_x;
				mb2        = px_q;
			end
			S_N_Y: begin
				// prefetch the next vertex while the y term issues
				vram_raddr = last_v ? VAW'(idx_q) : VAW'(idx_nx);
				mop.valid  = 1'b1;
				mop.last   = 1'b1;
				mop.tag    = INDEX_W'(idx_q);
				ma1        = vtx_y;
				ma2        = py_q;
				mb1        = vtx_y;
				mb2        = py_q;
			end
			S_N_WAIT: begin
				if (!mac_busy) begin
					rv_d    = 1'b1;
					rstat_d = found_q ? STAT_OK : STAT_NONE;
					ridx_d  = found_q ? fidx_q : '0;
				end
			end
			default: begin
				rv_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			vcount_q <= '0;
			tcount_q <= '0;
			limit_q  <= LIMIT_RESET;
			done     <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= rv_d;
			if (distance_limit_we) begin
				limit_q <= distance_limit_wdata;
			end
			if (accept) begin
				case (command)
					CMD_LOAD_VTX: begin
						if (!vfull) begin
							vcount_q <= vcount_q + VCW'(1);
						end
					end
					CMD_LOAD_TRI: begin
						if (!tfull) begin
							tcount_q <= tcount_q + TCW'(1);
						end
					end
					CMD_CLEAR: begin
						vcount_q <= '0;
						tcount_q <= '0;
					end
					default: begin
						vcount_q <= vcount_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		status      <= rstat_d;
		found_index <= ridx_d;

		// fold in each finished sum from the shared unit
		if (mres.valid) begin
			if (cmd_q == CMD_LOCATE) begin
				ok_q <= ok_q & acc_pos;
			end else if (closer) begin
				best_q  <= sum_sq;
				fidx_q  <= mres.tag;
				found_q <= 1'b1;
			end
		end

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q   <= command;
					px_q    <= point_x;
					py_q    <= point_y;
					idx_q   <= '0;
					best_q  <= CMP_W'(limit_q) << SHIFT;
					found_q <= 1'b0;
					fidx_q  <= '0;
				end
			end
			S_L_CHK: begin
				if (tri_bad) begin
					idx_q <= idx_nx;
				end else begin
					c1_q <= tri_b;
					c2_q <= tri_c;
					k_q  <= '0;
					ok_q <= 1'b1;
				end
			end
			S_L_VTX: begin
				// shift corners in so v0, v1, v2 end up as a, b, c
				v0x_q <= v1x_q;
				v0y_q <= v1y_q;
				v1x_q <= v2x_q;
				v1y_q <= v2y_q;
				v2x_q <= vtx_x;
				v2y_q <= vtx_y;
				c1_q  <= c2_q;
				k_q   <= k_q + 2'd1;
				j_q   <= '0;
			end
			S_L_MUL: begin
				j_q <= j_q + 3'd1;
				if (j_q[0]) begin
					// rotate so the next edge again runs v0 to v1
					v0x_q <= v1x_q;
					v0y_q <= v1y_q;
					v1x_q <= v2x_q;
					v1y_q <= v2y_q;
					v2x_q <= v0x_q;
					v2y_q <= v0y_q;
				end
			end
			S_L_WAIT: begin
				if (!mac_busy && !ok_q) begin
					idx_q <= idx_nx;
				end
			end
			S_N_Y: begin
				if (!last_v) begin
					idx_q <= idx_nx;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

endmodule

`default_nettype wire
